@@ hw/rtl/tdhh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the tank drive heading-hold mixer.
// No dependencies; imported by every module of the block.
package tdhh_pkg;

  // Field widths
  localparam int DRIVE_W   = 16;
  localparam int HEADING_W = 22;
  localparam int RATE_W    = 18;
  localparam int GAIN_W    = 24;
  localparam int RATIO_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_RATIO = 2'd2;

  // Action codes
  localparam int ACTION_W = 2;
  localparam logic [ACTION_W-1:0] ACT_TANK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GYRO  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

  // Derived arithmetic widths
  localparam int ERR_W  = HEADING_W + 1;              // target minus heading
  localparam int PH_W   = GAIN_W + 1 + ERR_W;         // P product
  localparam int PR_W   = GAIN_W + 1 + RATE_W;        // D product
  localparam int SUM_W  = ((PH_W > PR_W) ? PH_W : PR_W) + 1;
  localparam int SHIFT  = 31 - DRIVE_W;               // PD sum to drive scaling
  localparam int RND_W  = SUM_W - SHIFT;
  localparam int LIMPROD_W = DRIVE_W + 1 + RATIO_W;   // |throttle| * ratio
  localparam logic [DRIVE_W-1:0] TENTH =
      DRIVE_W'(((1 << (DRIVE_W - 1)) + 5) / 10);

  // Stage 1: accepted item with state applied
  typedef struct packed {
    logic signed [DRIVE_W-1:0] thr;
    logic signed [DRIVE_W-1:0] steer;
    logic signed [ERR_W-1:0]   err;
    logic signed [RATE_W-1:0]  rate;
    logic                      use_pd;
    logic                      hold;
  } s1_t;

  // Stage 2: products
  typedef struct packed {
    logic signed [DRIVE_W-1:0] thr;
    logic signed [DRIVE_W-1:0] steer;
    logic signed [PH_W-1:0]    prod_h;
    logic signed [PR_W-1:0]    prod_r;
    logic [DRIVE_W-1:0]        limit;
    logic                      use_pd;
    logic                      hold;
  } s2_t;

  // Stage 3: PD sum and effective limit
  typedef struct packed {
    logic signed [DRIVE_W-1:0] thr;
    logic signed [DRIVE_W-1:0] steer;
    logic signed [SUM_W-1:0]   sum;
    logic [DRIVE_W-1:0]        limit;
    logic                      use_pd;
    logic                      hold;
  } s3_t;

  // Stage 4: final steering value
  typedef struct packed {
    logic signed [DRIVE_W-1:0] thr;
    logic signed [DRIVE_W-1:0] steer;
    logic                      hold;
  } s4_t;

  // Stage load enables from the pipeline control
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } pd_en_t;

endpackage

@@ hw/rtl/tank_drive_heading_hold.sv @@
`timescale 1ns / 1ps
// Tank drive mixer with PD heading hold. One transaction is accepted per clock,
// and throughput is one item per cycle, unless backpressure stalls the pipeline;
// each plain or gyro-assisted item yields its result through five register
// stages (input/state, gain multipliers, PD sum, round and clamp, mix and
// saturate); heading reset and the unused action give no result. Each stage
// holds its item only while the stage after it is full, so bubbles are squeezed
// out under backpressure. Depends on tdhh_pkg, tdhh_front, tdhh_pd, tdhh_mix.
module tank_drive_heading_hold import tdhh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: throttle[15:0], steer_demand[31:16], heading[53:32], yaw_rate[71:54],
  //        imu_ready[72], zero pad[79:73]
  input  logic [79:0]           s_axis_tdata,
  // tuser: action[1:0]
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: left_cmd[15:0], right_cmd[31:16], hold_active[32], zero pad[39:33]
  output logic [39:0]           m_axis_tdata
);

  logic [GAIN_W-1:0]  heading_gain_q, rate_gain_q;
  logic [RATIO_W-1:0] correction_ratio_q;

  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic so_free, s4_free, s3_free, s2_free, s1_free;
  logic accept;

  s1_t    s1;
  s4_t    s4;
  pd_en_t pd_en;

  logic signed [DRIVE_W-1:0] left_cmd, right_cmd;
  logic                      hold_active;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_gain_q     <= '0;
      rate_gain_q        <= '0;
      correction_ratio_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADING_GAIN:     heading_gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_RATE_GAIN:        rate_gain_q        <= cfg_data_i[GAIN_W-1:0];
        CFG_CORRECTION_RATIO: correction_ratio_q <= cfg_data_i[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or moving on
  assign so_free = !vo_q || m_axis_tready;
  assign s4_free = !v4_q || so_free;
  assign s3_free = !v3_q || s4_free;
  assign s2_free = !v2_q || s3_free;
  assign s1_free = !v1_q || s2_free;
  assign s_axis_tready = s1_free;
  assign accept = s_axis_tvalid && s1_free;

  assign pd_en.ld2 = s2_free;
  assign pd_en.ld3 = s3_free;
  assign pd_en.ld4 = s4_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_q <= accept && ((s_axis_tuser == ACT_TANK) || (s_axis_tuser == ACT_GYRO));
      end
      if (s2_free) begin
        v2_q <= v1_q;
      end
      if (s3_free) begin
        v3_q <= v2_q;
      end
      if (s4_free) begin
        v4_q <= v3_q;
      end
      if (so_free) begin
        vo_q <= v4_q;
      end
    end
  end

  tdhh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .load_i         (s1_free),
    .action_i       (s_axis_tuser),
    .throttle_i     ($signed(s_axis_tdata[15:0])),
    .steer_demand_i ($signed(s_axis_tdata[31:16])),
    .heading_i      ($signed(s_axis_tdata[53:32])),
    .yaw_rate_i     ($signed(s_axis_tdata[71:54])),
    .imu_ready_i    (s_axis_tdata[72]),
    .s1_o           (s1)
  );

  tdhh_pd u_pd (
    .clk_i              (clk_i),
    .en_i               (pd_en),
    .heading_gain_i     (heading_gain_q),
    .rate_gain_i        (rate_gain_q),
    .correction_ratio_i (correction_ratio_q),
    .s1_i               (s1),
    .s4_o               (s4)
  );

  tdhh_mix u_mix (
    .clk_i         (clk_i),
    .load_i        (so_free),
    .s4_i          (s4),
    .left_cmd_o    (left_cmd),
    .right_cmd_o   (right_cmd),
    .hold_active_o (hold_active)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {7'b0, hold_active, right_cmd, left_cmd};

endmodule

@@ hw/rtl/tdhh_front.sv @@
`timescale 1ns / 1ps
// Input stage: hold-mode and target-heading state, heading error.
// Depends on tdhh_pkg.
module tdhh_front import tdhh_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        load_i,
  input  logic [ACTION_W-1:0]         action_i,
  input  logic signed [DRIVE_W-1:0]   throttle_i,
  input  logic signed [DRIVE_W-1:0]   steer_demand_i,
  input  logic signed [HEADING_W-1:0] heading_i,
  input  logic signed [RATE_W-1:0]    yaw_rate_i,
  input  logic                        imu_ready_i,
  output s1_t                         s1_o
);

  logic                        use_imu_q, use_imu_d;
  logic signed [HEADING_W-1:0] target_q, target_d;
  s1_t                         s1_q, s1_d;

  // State update for the transaction being accepted
  always_comb begin
    use_imu_d = use_imu_q;
    target_d  = target_q;
    case (action_i)
      ACT_RESET: begin
        use_imu_d = 1'b1;
        target_d  = '0;
      end
      ACT_GYRO: begin
        if (use_imu_q) begin
          if (!imu_ready_i) begin
            use_imu_d = 1'b0;
          end else if (steer_demand_i != '0) begin
            target_d = heading_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 1 payload; the error only matters when the target was not recaptured
  always_comb begin
    s1_d.thr    = throttle_i;
    s1_d.steer  = steer_demand_i;
    s1_d.err    = $signed({target_q[HEADING_W-1], target_q})
                - $signed({heading_i[HEADING_W-1], heading_i});
    s1_d.rate   = yaw_rate_i;
    s1_d.use_pd = (action_i == ACT_GYRO) && (steer_demand_i == '0) && use_imu_d;
    s1_d.hold   = use_imu_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_imu_q <= 1'b1;
      target_q  <= '0;
    end else if (accept_i) begin
      use_imu_q <= use_imu_d;
      target_q  <= target_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

@@ hw/rtl/tdhh_pd.sv @@
`timescale 1ns / 1ps
// PD correction datapath: products, sum and limit, rounding and clamp.
// Depends on tdhh_pkg.
module tdhh_pd import tdhh_pkg::*; (
  input  logic               clk_i,
  input  pd_en_t             en_i,
  input  logic [GAIN_W-1:0]  heading_gain_i,
  input  logic [GAIN_W-1:0]  rate_gain_i,
  input  logic [RATIO_W-1:0] correction_ratio_i,
  input  s1_t                s1_i,
  output s4_t                s4_o
);

  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  s4_t s4_q, s4_d;

  logic [DRIVE_W:0]           abs_thr;
  logic [LIMPROD_W-1:0]       lim_prod;
  logic                       neg;
  logic [SUM_W-1:0]           mag;
  logic [SUM_W-1:0]           mag_rnd;
  logic [RND_W-1:0]           rnd;
  logic [DRIVE_W-1:0]         clamped;
  logic signed [DRIVE_W-1:0]  pd_steer;

  // Stage 2: gain products and the throttle-scaled limit
  always_comb begin
    abs_thr = s1_i.thr[DRIVE_W-1]
            ? ((DRIVE_W+1)'(0) - {s1_i.thr[DRIVE_W-1], s1_i.thr})
            : {1'b0, s1_i.thr};
    lim_prod      = abs_thr * correction_ratio_i;
    s2_d.thr      = s1_i.thr;
    s2_d.steer    = s1_i.steer;
    s2_d.prod_h   = $signed({1'b0, heading_gain_i}) * s1_i.err;
    s2_d.prod_r   = $signed({1'b0, rate_gain_i}) * s1_i.rate;
    s2_d.limit    = lim_prod[RATIO_W+DRIVE_W-1:RATIO_W];
    s2_d.use_pd   = s1_i.use_pd;
    s2_d.hold     = s1_i.hold;
  end

  // Stage 3: PD sum, limit floor of one tenth
  always_comb begin
    s3_d.thr    = s2_q.thr;
    s3_d.steer  = s2_q.steer;
    s3_d.sum    = SUM_W'(s2_q.prod_h) - SUM_W'(s2_q.prod_r);
    s3_d.limit  = (s2_q.limit < TENTH) ? TENTH : s2_q.limit;
    s3_d.use_pd = s2_q.use_pd;
    s3_d.hold   = s2_q.hold;
  end

  // Stage 4: round magnitude half away from zero, clamp, restore sign
  always_comb begin
    neg      = s3_q.sum[SUM_W-1];
    mag      = neg ? (SUM_W'(0) - s3_q.sum) : s3_q.sum;
    mag_rnd  = mag + (SUM_W'(1) << (SHIFT - 1));
    rnd      = mag_rnd[SUM_W-1:SHIFT];
    clamped  = (rnd > RND_W'(s3_q.limit)) ? s3_q.limit : rnd[DRIVE_W-1:0];
    pd_steer = neg ? $signed(DRIVE_W'(0) - clamped) : $signed(clamped);
    s4_d.thr   = s3_q.thr;
    s4_d.steer = s3_q.use_pd ? pd_steer : s3_q.steer;
    s4_d.hold  = s3_q.hold;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld2) begin
      s2_q <= s2_d;
    end
    if (en_i.ld3) begin
      s3_q <= s3_d;
    end
    if (en_i.ld4) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule

@@ hw/rtl/tdhh_mix.sv @@
`timescale 1ns / 1ps
// Output stage: tank mix, saturation and right-side negation.
// Depends on tdhh_pkg.
module tdhh_mix import tdhh_pkg::*; (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  s4_t                       s4_i,
  output logic signed [DRIVE_W-1:0] left_cmd_o,
  output logic signed [DRIVE_W-1:0] right_cmd_o,
  output logic                      hold_active_o
);

  localparam int MIX_W = DRIVE_W + 2;
  localparam logic signed [MIX_W-1:0] POS_MAX = MIX_W'((1 << (DRIVE_W - 1)) - 1);
  localparam logic signed [MIX_W-1:0] NEG_MAX = -MIX_W'(1 << (DRIVE_W - 1));

  logic signed [MIX_W-1:0]   thr_x, steer_x, left_sum, right_neg;
  logic signed [DRIVE_W-1:0] left_q, left_d, right_q, right_d;
  logic                      hold_q;

  function automatic logic signed [DRIVE_W-1:0] sat(input logic signed [MIX_W-1:0] v);
    logic signed [DRIVE_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[DRIVE_W-1:0];
    end else if (v < NEG_MAX) begin
      r = NEG_MAX[DRIVE_W-1:0];
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

  // left = throttle - steer, right sent as -(throttle + steer)
  always_comb begin
    thr_x     = MIX_W'(s4_i.thr);
    steer_x   = MIX_W'(s4_i.steer);
    left_sum  = thr_x - steer_x;
    right_neg = MIX_W'(0) - thr_x - steer_x;
    left_d    = sat(left_sum);
    right_d   = sat(right_neg);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      hold_q  <= s4_i.hold;
    end
  end

  assign left_cmd_o    = left_q;
  assign right_cmd_o   = right_q;
  assign hold_active_o = hold_q;

endmodule
